// ----- design/scnim_pkg.sv -----
// ----------------------------------------------------------------------------
// scnim_pkg
// Shared types, register codes and constant functions for the soft clipper
// with noise injection and dry/wet mix.
// ----------------------------------------------------------------------------
package scnim_pkg;

  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRE_GAIN        = 3'd0,
    CFG_POST_GAIN       = 3'd1,
    CFG_DRY_SHARE       = 3'd2,
    CFG_CLIP_THRESHOLD  = 3'd3,
    CFG_KNEE_AMOUNT     = 3'd4,
    CFG_RATIO_INVERSE   = 3'd5,
    CFG_NOISE_THRESHOLD = 3'd6
  } cfg_idx_t;

  localparam logic [15:0] PRE_GAIN_RST        = 16'd8192;
  localparam logic [15:0] POST_GAIN_RST       = 16'd8192;
  localparam logic [16:0] DRY_SHARE_RST       = 17'd65536;
  localparam logic [15:0] CLIP_THRESHOLD_RST  = 16'd65535;
  localparam logic [16:0] KNEE_AMOUNT_RST     = 17'd65536;
  localparam logic [16:0] RATIO_INVERSE_RST   = 17'd65536;
  localparam logic [16:0] NOISE_THRESHOLD_RST = 17'd32768;

  // log2(e) in Q24 and ln(2) in Q62.
  localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
  localparam logic [63:0] LN2_Q62   = 64'h2C5C85FDF473DE6B;

  // round(exp(-x) * 2^30) for x = ln2-scaled table point, by a Taylor series of
  // exp(-x) in Q62. Used only with constant arguments.
  function automatic logic [30:0] exp_entry(input logic [63:0] x);
    logic [63:0]  term;
    logic [63:0]  pos;
    logic [63:0]  neg;
    logic [63:0]  sum;
    logic [127:0] pr;
    term = 64'h4000000000000000;
    pos  = term;
    neg  = 64'd0;
    for (int k = 1; k <= 24; k++) begin
      pr   = 128'(term) * 128'(x);
      term = pr[125:62] / 64'(k);
      if ((k & 1) != 0) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    sum = pos - neg + 64'h0000000080000000;
    return sum[62:32];
  endfunction

endpackage

// ----- design/scnim_if.sv -----
// ----------------------------------------------------------------------------
// scnim_in_if / scnim_out_if
// Valid/ready channels for sample items entering and leaving the mixer.
// ----------------------------------------------------------------------------
interface scnim_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic signed [SAMPLE_BITS-1:0] noise_sample;
  modport source(output valid, in_sample, noise_sample, input ready);
  modport sink(input valid, in_sample, noise_sample, output ready);
endinterface

interface scnim_out_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          saturated;
  modport source(output valid, out_sample, saturated, input ready);
  modport sink(input valid, out_sample, saturated, output ready);
endinterface

// ----- design/scnim_div.sv -----
// ----------------------------------------------------------------------------
// scnim_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside each item.
// ----------------------------------------------------------------------------
module scnim_div import scnim_pkg::*; #(
  parameter int NW  = 44,
  parameter int SDW = 52
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_v,
  input  logic [NW-1:0]  num,
  input  logic [SDW-1:0] side,
  input  logic [16:0]    den,
  output logic           out_v,
  output logic [NW-1:0]  quo,
  output logic [SDW-1:0] out_side
);

  logic [16:0]    rem_r  [NW];
  logic [NW-1:0]  num_r  [NW];
  logic [SDW-1:0] side_r [NW];
  logic           v_r    [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [16:0]   rem_prev;
    logic [NW-1:0] num_prev;
    logic [16:0]   rn;
    logic          ge;
    logic [16:0]   rem_nxt;
    logic [NW-1:0] num_nxt;

    if (i == 0) begin : g_first
      assign rem_prev = 17'd0;
      assign num_prev = num;
    end else begin : g_next
      assign rem_prev = rem_r[i-1];
      assign num_prev = num_r[i-1];
    end

    // Remainder stays below the divisor, so its low 16 bits carry it all.
    assign rn      = {rem_prev[15:0], num_prev[NW-1]};
    assign ge      = (rn >= den);
    assign rem_nxt = ge ? (rn - den) : rn;
    assign num_nxt = {num_prev[NW-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= (i == 0) ? in_v : v_r[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i]  <= rem_nxt;
        num_r[i]  <= num_nxt;
        side_r[i] <= (i == 0) ? side : side_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign out_v    = v_r[NW-1];
  assign quo      = num_r[NW-1];
  assign out_side = side_r[NW-1];

endmodule

// ----- design/scnim_shape.sv -----
// ----------------------------------------------------------------------------
// scnim_shape
// Exponential soft-knee shaping of the excess above the clip threshold:
// exp by table and shift, then scaling by the excess and the inverse ratio.
// ----------------------------------------------------------------------------
module scnim_shape import scnim_pkg::*; #(
  parameter int SAMPLE_BITS     = 24,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            in_v,
  input  logic [SAMPLE_BITS+18:0]         ku,
  input  logic                            over,
  input  logic signed [SAMPLE_BITS+2:0]   s_in,
  input  logic signed [SAMPLE_BITS-1:0]   noise_in,
  input  logic [SAMPLE_BITS-2:0]          thr_q,
  input  logic [16:0]                     rinv,
  output logic                            out_v,
  output logic signed [SAMPLE_BITS+5:0]   clipped,
  output logic [SAMPLE_BITS+5:0]          amount,
  output logic signed [SAMPLE_BITS+2:0]   s_out,
  output logic signed [SAMPLE_BITS-1:0]   noise_out
);

  localparam int F  = SAMPLE_BITS - 1;
  localparam int SW = SAMPLE_BITS + 3;
  localparam int EW = SAMPLE_BITS + 2;
  localparam int NW = EW + 17;
  localparam int CW = SAMPLE_BITS + 6;
  localparam int YW = SAMPLE_BITS + 31;
  localparam int IW = $clog2(EXP_TABLE_DEPTH);
  localparam logic [NW-1:0] KU_MAX  = NW'(64) << F;
  localparam logic [63:0]   LN2_DIV = LN2_Q62 / EXP_TABLE_DEPTH;
  localparam logic [63:0]   LN2_MOD = LN2_Q62 % EXP_TABLE_DEPTH;

  logic [30:0] tab [EXP_TABLE_DEPTH];

  for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_tab
    localparam logic [63:0] XI = LN2_DIV * 64'(i) + (LN2_MOD * 64'(i)) / EXP_TABLE_DEPTH;
    assign tab[i] = exp_entry(XI);
  end

  // Stage A: knee product times log2(e).
  logic                   a_v_r;
  logic                   a_ok_r;
  logic                   a_over_r;
  logic [YW-1:0]          a_ym_r;
  logic [EW-1:0]          a_e_r;
  logic signed [SW-1:0]   a_s_r;
  logic signed [F:0]      a_noise_r;
  logic [SW-1:0]          a_dif;

  assign a_dif = s_in - SW'(thr_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ok_r    <= over && (ku <= KU_MAX);
      a_over_r  <= over;
      a_ym_r    <= YW'(ku[SAMPLE_BITS+5:0]) * YW'(LOG2E_Q24);
      a_e_r     <= a_dif[EW-1:0];
      a_s_r     <= s_in;
      a_noise_r <= noise_in;
    end
  end

  // Stage B: split into integer shift and table index.
  logic                   b_v_r;
  logic                   b_zero_r;
  logic                   b_over_r;
  logic [4:0]             b_n_r;
  logic [IW-1:0]          b_idx_r;
  logic [EW-1:0]          b_e_r;
  logic signed [SW-1:0]   b_s_r;
  logic signed [F:0]      b_noise_r;
  logic [SAMPLE_BITS+6:0] b_y;
  logic [7:0]             b_n;
  logic [F+IW:0]          b_fd;

  assign b_y  = a_ym_r[YW-1:24];
  assign b_n  = b_y[SAMPLE_BITS+6:F];
  assign b_fd = (F+IW+1)'(b_y[F-1:0]) * (F+IW+1)'(EXP_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_zero_r  <= !a_ok_r || (b_n > 8'd30);
      b_n_r     <= b_n[4:0];
      b_idx_r   <= b_fd[F+IW-1:F];
      b_over_r  <= a_over_r;
      b_e_r     <= a_e_r;
      b_s_r     <= a_s_r;
      b_noise_r <= a_noise_r;
    end
  end

  // Stage C: table lookup and shift.
  logic                 c_v_r;
  logic                 c_over_r;
  logic [30:0]          c_expv_r;
  logic [EW-1:0]        c_e_r;
  logic signed [SW-1:0] c_s_r;
  logic signed [F:0]    c_noise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_expv_r  <= b_zero_r ? 31'd0 : (tab[b_idx_r] >> b_n_r);
      c_over_r  <= b_over_r;
      c_e_r     <= b_e_r;
      c_s_r     <= b_s_r;
      c_noise_r <= b_noise_r;
    end
  end

  // Stage D: excess times exp.
  logic                 d_v_r;
  logic                 d_over_r;
  logic [EW+30:0]       d_prod_r;
  logic signed [SW-1:0] d_s_r;
  logic signed [F:0]    d_noise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (adv) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_prod_r  <= (EW+31)'(c_e_r) * (EW+31)'(c_expv_r);
      d_over_r  <= c_over_r;
      d_s_r     <= c_s_r;
      d_noise_r <= c_noise_r;
    end
  end

  // Stage E: round the shaped term, apply inverse ratio.
  logic                 e_v_r;
  logic                 e_over_r;
  logic [EW+17:0]       e_prod_r;
  logic signed [SW-1:0] e_s_r;
  logic signed [F:0]    e_noise_r;
  logic [EW+31:0]       e_sum;

  assign e_sum = (EW+32)'(d_prod_r) + (EW+32)'(32'h20000000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (adv) begin
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_prod_r  <= (EW+18)'(e_sum[EW+30:30]) * (EW+18)'(rinv);
      e_over_r  <= d_over_r;
      e_s_r     <= d_s_r;
      e_noise_r <= d_noise_r;
    end
  end

  // Stage F: offset by the threshold and measure the clipped amount.
  logic [EW+18:0]       f_sum;
  logic signed [CW-1:0] f_clip;
  logic signed [CW:0]   f_dif;
  logic                 f_v_r;
  logic signed [CW-1:0] f_clip_r;
  logic [CW-1:0]        f_amt_r;
  logic signed [SW-1:0] f_s_r;
  logic signed [F:0]    f_noise_r;

  assign f_sum = (EW+19)'(e_prod_r) + (EW+19)'(17'h08000);

  always_comb begin
    if (e_over_r) begin
      f_clip = $signed(CW'(thr_q) + CW'(f_sum[EW+17:16]));
    end else begin
      f_clip = CW'(e_s_r);
    end
    f_dif = (CW+1)'(f_clip) - (CW+1)'(e_s_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (adv) begin
      f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_clip_r  <= f_clip;
      f_amt_r   <= f_dif[CW] ? CW'(-f_dif) : f_dif[CW-1:0];
      f_s_r     <= e_s_r;
      f_noise_r <= e_noise_r;
    end
  end

  assign out_v     = f_v_r;
  assign clipped   = f_clip_r;
  assign amount    = f_amt_r;
  assign s_out     = f_s_r;
  assign noise_out = f_noise_r;

endmodule

// ----- design/soft_clip_noise_inject_mix.sv -----
// ----------------------------------------------------------------------------
// soft_clip_noise_inject_mix
// Pre-gain, exponential soft clip, noise injection and dry/wet mix per sample.
// ----------------------------------------------------------------------------
// Each input item carries one audio sample and the filtered noise value for
// the same sample index; each output item carries the mixed, saturated
// sample and a flag that is set when it was clamped. Both channels use
// valid/ready; an item moves when both are high.
// The block is a fixed pipeline that accepts one item per cycle while the
// output is not stalled. Its longest part is the knee normalization,
// a divider that resolves one quotient bit per stage.
// When the receiver holds ready low while a result is waiting, the whole
// pipeline holds and in_ch.ready falls in the same cycle; nothing is lost
// or repeated. Reset empties the pipeline and loads the register defaults.
// Configuration is written through cfg_we/cfg_idx/cfg_data, one register
// per write, and should only change while no item is in flight.
// ----------------------------------------------------------------------------
module soft_clip_noise_inject_mix import scnim_pkg::*; #(
  parameter int SAMPLE_BITS     = 24,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  scnim_in_if.sink              in_ch,
  scnim_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SB  = SAMPLE_BITS;
  localparam int F   = SB - 1;
  localparam int SW  = SB + 3;
  localparam int EW  = SB + 2;
  localparam int NW  = EW + 17;
  localparam int CW  = SB + 6;
  localparam int XW  = (CW > 32) ? 32 : CW;
  localparam int C2W = SB + 8;
  localparam int WW  = C2W + 4;
  localparam int AW  = WW + 19;
  localparam int RW  = AW - 16;
  localparam int SDW = 1 + SW + SB;
  localparam logic [CW-1:0]        X_MAX  = CW'({XW{1'b1}});
  localparam logic signed [RW-1:0] OUT_HI = $signed({{(RW-F){1'b0}}, {F{1'b1}}});
  localparam logic signed [RW-1:0] OUT_LO = $signed({{(RW-F){1'b1}}, {F{1'b0}}});

  // Configuration registers.
  logic [15:0] pre_gain_r;
  logic [15:0] post_gain_r;
  logic [16:0] dry_share_r;
  logic [15:0] clip_threshold_r;
  logic [16:0] knee_amount_r;
  logic [16:0] ratio_inverse_r;
  logic [16:0] noise_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_gain_r        <= PRE_GAIN_RST;
      post_gain_r       <= POST_GAIN_RST;
      dry_share_r       <= DRY_SHARE_RST;
      clip_threshold_r  <= CLIP_THRESHOLD_RST;
      knee_amount_r     <= KNEE_AMOUNT_RST;
      ratio_inverse_r   <= RATIO_INVERSE_RST;
      noise_threshold_r <= NOISE_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_PRE_GAIN:        pre_gain_r        <= cfg_data[15:0];
        CFG_POST_GAIN:       post_gain_r       <= cfg_data[15:0];
        CFG_DRY_SHARE:       dry_share_r       <= cfg_data;
        CFG_CLIP_THRESHOLD:  clip_threshold_r  <= cfg_data[15:0];
        CFG_KNEE_AMOUNT:     knee_amount_r     <= cfg_data;
        CFG_RATIO_INVERSE:   ratio_inverse_r   <= cfg_data;
        CFG_NOISE_THRESHOLD: noise_threshold_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Thresholds brought from Q0.16 to the sample format by truncation.
  logic [F+15:0] thr_ext;
  logic [F-1:0]  thr_q;
  logic [F+16:0] nthr_ext;
  logic [F:0]    nthr_q;
  logic [16:0]   den;

  assign thr_ext  = {clip_threshold_r, {F{1'b0}}};
  assign thr_q    = thr_ext[F+15:16];
  assign nthr_ext = {noise_threshold_r, {F{1'b0}}};
  assign nthr_q   = nthr_ext[F+16:16];
  assign den      = 17'h10000 - {1'b0, clip_threshold_r};

  logic adv;
  logic out_v_r;

  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 1: pre-gain product.
  logic                  s1_v_r;
  logic signed [SB+16:0] s1_prod_r;
  logic signed [SB-1:0]  s1_noise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod_r  <= in_ch.in_sample * $signed({1'b0, pre_gain_r});
      s1_noise_r <= in_ch.noise_sample;
    end
  end

  // Stage 2: round to the sample format, compare with the threshold.
  logic signed [SB+17:0] s2_sum;
  logic signed [SB+17:0] s2_sh;
  logic                  s2_v_r;
  logic signed [SW-1:0]  s2_s_r;
  logic                  s2_over_r;
  logic signed [SB-1:0]  s2_noise_r;

  assign s2_sum = (SB+18)'(s1_prod_r) + (SB+18)'(13'd4096) - (SB+18)'(s1_prod_r[SB+16]);
  assign s2_sh  = s2_sum >>> 13;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_s_r     <= s2_sh[SW-1:0];
      s2_over_r  <= $signed(s2_sh[SW-1:0]) > $signed({1'b0, thr_q});
      s2_noise_r <= s1_noise_r;
    end
  end

  // Stage 3: excess times knee, the dividend of the normalization.
  logic [SW-1:0]        s3_dif;
  logic                 s3_v_r;
  logic [NW-1:0]        s3_nk_r;
  logic                 s3_over_r;
  logic signed [SW-1:0] s3_s_r;
  logic signed [SB-1:0] s3_noise_r;

  assign s3_dif = s2_s_r - SW'(thr_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_nk_r    <= s2_over_r ? (NW'(s3_dif[EW-1:0]) * NW'(knee_amount_r)) : '0;
      s3_over_r  <= s2_over_r;
      s3_s_r     <= s2_s_r;
      s3_noise_r <= s2_noise_r;
    end
  end

  logic                 dv_v;
  logic [NW-1:0]        dv_quo;
  logic [SDW-1:0]       dv_side;

  scnim_div #(
    .NW  (NW),
    .SDW (SDW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (s3_v_r),
    .num      (s3_nk_r),
    .side     ({s3_over_r, s3_s_r, s3_noise_r}),
    .den      (den),
    .out_v    (dv_v),
    .quo      (dv_quo),
    .out_side (dv_side)
  );

  logic                 sh_v;
  logic signed [CW-1:0] sh_clip;
  logic [CW-1:0]        sh_amt;
  logic signed [SW-1:0] sh_s;
  logic signed [SB-1:0] sh_noise;

  scnim_shape #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_shape (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_v      (dv_v),
    .ku        (dv_quo),
    .over      (dv_side[SDW-1]),
    .s_in      ($signed(dv_side[SW+SB-1:SB])),
    .noise_in  ($signed(dv_side[SB-1:0])),
    .thr_q     (thr_q),
    .rinv      (ratio_inverse_r),
    .out_v     (sh_v),
    .clipped   (sh_clip),
    .amount    (sh_amt),
    .s_out     (sh_s),
    .noise_out (sh_noise)
  );

  // Stage G: noise excess, capped, and its sign.
  logic [CW-1:0]        g_ex_full;
  logic                 g_v_r;
  logic                 g_go_r;
  logic                 g_neg_r;
  logic [XW-1:0]        g_ex_r;
  logic [SB-1:0]        g_nm_r;
  logic signed [CW-1:0] g_clip_r;
  logic signed [SW-1:0] g_s_r;

  assign g_ex_full = sh_amt - CW'(nthr_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (adv) begin
      g_v_r <= sh_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_go_r   <= sh_amt > CW'(nthr_q);
      g_neg_r  <= sh_clip[CW-1] ^ sh_noise[SB-1];
      g_ex_r   <= (g_ex_full > X_MAX) ? XW'(X_MAX) : g_ex_full[XW-1:0];
      g_nm_r   <= sh_noise[SB-1] ? SB'(-sh_noise) : sh_noise;
      g_clip_r <= sh_clip;
      g_s_r    <= sh_s;
    end
  end

  // Stage H: excess times noise magnitude.
  logic                 h_v_r;
  logic                 h_go_r;
  logic                 h_neg_r;
  logic [XW+SB-1:0]     h_prod_r;
  logic signed [CW-1:0] h_clip_r;
  logic signed [SW-1:0] h_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (adv) begin
      h_v_r <= g_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_prod_r <= (XW+SB)'(g_ex_r) * (XW+SB)'(g_nm_r);
      h_go_r   <= g_go_r;
      h_neg_r  <= g_neg_r;
      h_clip_r <= g_clip_r;
      h_s_r    <= g_s_r;
    end
  end

  // Stage I: add the rounded noise term.
  logic [XW+SB:0]        i_sum;
  logic signed [C2W-1:0] i_p;
  logic signed [C2W-1:0] i_add;
  logic                  i_v_r;
  logic signed [C2W-1:0] i_clip_r;
  logic signed [SW-1:0]  i_s_r;

  assign i_sum = (XW+SB+1)'(h_prod_r) + ((XW+SB+1)'(1) << (F-1));
  assign i_p   = $signed(C2W'(i_sum[XW+SB:F]));
  always_comb begin
    if (!h_go_r) begin
      i_add = '0;
    end else if (h_neg_r) begin
      i_add = -i_p;
    end else begin
      i_add = i_p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_v_r <= 1'b0;
    end else if (adv) begin
      i_v_r <= h_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_clip_r <= C2W'(h_clip_r) + i_add;
      i_s_r    <= h_s_r;
    end
  end

  // Stage J: post-gain product.
  logic                   j_v_r;
  logic signed [C2W+16:0] j_prod_r;
  logic signed [SW-1:0]   j_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_v_r <= 1'b0;
    end else if (adv) begin
      j_v_r <= i_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_prod_r <= i_clip_r * $signed({1'b0, post_gain_r});
      j_s_r    <= i_s_r;
    end
  end

  // Stage K: round the wet path, form both mix products.
  logic signed [C2W+17:0] k_sum;
  logic signed [C2W+17:0] k_sh;
  logic signed [WW-1:0]   k_wet;
  logic signed [17:0]     k_wd;
  logic                   k_v_r;
  logic signed [SW+17:0]  k_sd_r;
  logic signed [WW+17:0]  k_ww_r;

  assign k_sum = (C2W+18)'(j_prod_r) + (C2W+18)'(13'd4096) - (C2W+18)'(j_prod_r[C2W+16]);
  assign k_sh  = k_sum >>> 13;
  assign k_wet = k_sh[WW-1:0];
  assign k_wd  = 18'sd65536 - $signed({1'b0, dry_share_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_v_r <= 1'b0;
    end else if (adv) begin
      k_v_r <= j_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_sd_r <= j_s_r * $signed({1'b0, dry_share_r});
      k_ww_r <= k_wet * k_wd;
    end
  end

  // Stage L: sum, round, saturate into the output register.
  logic signed [AW-1:0] l_acc;
  logic signed [AW-1:0] l_sum;
  logic signed [AW-1:0] l_sh;
  logic signed [RW-1:0] l_res;
  logic signed [SB-1:0] out_sample_r;
  logic                 saturated_r;

  assign l_acc = AW'(k_sd_r) + AW'(k_ww_r);
  assign l_sum = l_acc + AW'(17'h08000) - AW'(l_acc[AW-1]);
  assign l_sh  = l_sum >>> 16;
  assign l_res = l_sh[RW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= k_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      priority if (l_res > OUT_HI) begin
        out_sample_r <= OUT_HI[SB-1:0];
        saturated_r  <= 1'b1;
      end else if (l_res < OUT_LO) begin
        out_sample_r <= OUT_LO[SB-1:0];
        saturated_r  <= 1'b1;
      end else begin
        out_sample_r <= l_res[SB-1:0];
        saturated_r  <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.out_sample = out_sample_r;
  assign out_ch.saturated  = saturated_r;

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the soft clipper with noise injection and dry/wet
// mix. Items are driven with random gaps and output stalls, each accepted
// item is predicted in fixed point, and every result is compared in order.
// ----------------------------------------------------------------------------
module tb_top;
  import scnim_pkg::*;

  localparam int SB      = 24;
  localparam int LATENCY = SB + 34;
  localparam int LIMIT   = 400000;

  typedef struct {
    logic signed [SB-1:0] sample;
    logic                 sat;
  } mix_result_t;

  class mix_scoreboard;
    longint unsigned regs[7];
    longint unsigned exp_lut[256];
    mix_result_t     pending[$];
    int              errors;

    function new();
      longint unsigned ln2, x, term, pos, neg;
      logic [127:0]    pr;
      ln2 = 64'h2C5C85FDF473DE6B;
      errors = 0;
      regs = '{8192, 8192, 65536, 65535, 65536, 65536, 32768};
      // Table of 2^(-i/256) in Q30 from a series of exp(-i*ln2/256).
      for (int i = 0; i < 256; i++) begin
        x = (ln2 / 256) * i + ((ln2 % 256) * i) / 256;
        term = 64'h4000000000000000;
        pos = term;
        neg = 0;
        for (int k = 1; k <= 24; k++) begin
          pr = 128'(term) * 128'(x);
          term = pr[125:62] / longint'(k);
          if (k % 2 == 1) neg += term; else pos += term;
        end
        exp_lut[i] = ((pos - neg) + 64'h80000000) >> 32;
      end
    endfunction

    function void set_reg(cfg_idx_t idx, longint unsigned val);
      int w;
      w = (idx == CFG_PRE_GAIN || idx == CFG_POST_GAIN || idx == CFG_CLIP_THRESHOLD)
          ? 16 : 17;
      regs[idx] = val & ((64'd1 << w) - 1);
    endfunction

    function longint round_shift(longint v, int s);
      longint unsigned mag, r;
      mag = v < 0 ? -v : v;
      r = (mag + (64'd1 << (s - 1))) >> s;
      return v < 0 ? -longint'(r) : longint'(r);
    endfunction

    function void note_input(logic signed [SB-1:0] xin, logic signed [SB-1:0] nin);
      longint          x, nz, s, clipped, t, amount, nt, wet, acc, res;
      longint unsigned e, ku, expv, shaped, y, n, f, idx, ex, nm, p;
      mix_result_t     r;
      x = xin;
      nz = nin;
      r.sat = 1'b0;
      s = round_shift(x * longint'(regs[CFG_PRE_GAIN]), 13);
      t = longint'((regs[CFG_CLIP_THRESHOLD] << 23) >> 16);
      clipped = s;
      // Only the positive side is shaped.
      if (s > t) begin
        e = s - t;
        ku = (e * regs[CFG_KNEE_AMOUNT]) / (64'd65536 - regs[CFG_CLIP_THRESHOLD]);
        expv = 0;
        if (ku <= (64'd64 << 23)) begin
          y = (ku * 64'd24204406) >> 24;
          n = y >> 23;
          f = y & ((64'd1 << 23) - 1);
          idx = (f * 256) >> 23;
          if (n < 31) expv = exp_lut[idx] >> n;
        end
        shaped = (e * expv + (64'd1 << 29)) >> 30;
        shaped = (shaped * regs[CFG_RATIO_INVERSE] + (64'd1 << 15)) >> 16;
        clipped = t + longint'(shaped);
      end
      amount = clipped - s;
      if (amount < 0) amount = -amount;
      nt = longint'((regs[CFG_NOISE_THRESHOLD] << 23) >> 16);
      if (amount > nt) begin
        ex = amount - nt;
        nm = nz < 0 ? -nz : nz;
        if (ex > 64'hFFFFFFFF) ex = 64'hFFFFFFFF;
        p = (ex * nm + (64'd1 << 22)) >> 23;
        if ((clipped < 0) != (nz < 0)) clipped -= longint'(p);
        else clipped += longint'(p);
      end
      wet = round_shift(clipped * longint'(regs[CFG_POST_GAIN]), 13);
      acc = s * longint'(regs[CFG_DRY_SHARE]) + (65536 - longint'(regs[CFG_DRY_SHARE])) * wet;
      res = round_shift(acc, 16);
      if (res > 64'sd8388607) begin
        res = 8388607;
        r.sat = 1'b1;
      end
      if (res < -64'sd8388608) begin
        res = -8388608;
        r.sat = 1'b1;
      end
      r.sample = res[SB-1:0];
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check(logic signed [SB-1:0] got, logic got_sat);
      mix_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %0d sat %0d", got, got_sat));
      end else begin
        want = pending.pop_front();
        if (got !== want.sample)
          report($sformatf("out_sample got %0d want %0d", got, want.sample));
        if (got_sat !== want.sat)
          report($sformatf("saturated got %0d want %0d", got_sat, want.sat));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  bit                    calm = 1'b0;
  int                    cycles = 0;
  mix_scoreboard         sb = new();

  scnim_in_if  #(.SAMPLE_BITS(SB)) in_ch();
  scnim_out_if #(.SAMPLE_BITS(SB)) out_ch();

  soft_clip_noise_inject_mix #(.SAMPLE_BITS(SB), .EXP_TABLE_DEPTH(256)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_sample = '0;
    in_ch.noise_sample = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check(out_ch.out_sample, out_ch.saturated);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("soft_clip_noise_inject_mix verification failed");
      $finish;
    end
  end

  // Entered and left at a falling edge.
  task send_item(logic signed [SB-1:0] x, logic signed [SB-1:0] nz);
    while (!calm && $urandom_range(99) < 32) begin
      in_ch.valid = 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.in_sample = x;
    in_ch.noise_sample = nz;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(x, nz);
    @(negedge clk);
  endtask

  task drain();
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    @(negedge clk);
  endtask

  task write_reg(cfg_idx_t idx, longint unsigned val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val[CFG_DATA_W-1:0];
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task write_all(longint unsigned pre, post, dry, thr, knee, rinv, nthr);
    drain();
    write_reg(CFG_PRE_GAIN, pre);
    write_reg(CFG_POST_GAIN, post);
    write_reg(CFG_DRY_SHARE, dry);
    write_reg(CFG_CLIP_THRESHOLD, thr);
    write_reg(CFG_KNEE_AMOUNT, knee);
    write_reg(CFG_RATIO_INVERSE, rinv);
    write_reg(CFG_NOISE_THRESHOLD, nthr);
  endtask

  // Mostly in range, sometimes at an edge of the range or anywhere in the field.
  function automatic longint unsigned pick_reg(int lo, int hi, int w);
    case ($urandom_range(7))
      0: return 64'(lo);
      1: return 64'(hi);
      2: return 64'($urandom_range((1 << w) - 1));
      default: return 64'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(3))
      0: return 24'($urandom_range(8388607, 8388607 - 65535));
      1: return 24'(-$urandom_range(8388608, 8388608 - 65535));
      2: return 24'($signed(24'($urandom_range(65535))) - 32768);
      default: return 24'($urandom);
    endcase
  endfunction

  task directed_set();
    send_item(24'sd8388607, 24'sd8388607);
    send_item(-24'sd8388608, -24'sd8388608);
    send_item(24'sd0, 24'sd8388607);
    send_item(24'sd8388607, -24'sd8388608);
    send_item(-24'sd8388608, 24'sd8388607);
    send_item(24'sd4194304, 24'sd1);
    send_item(-24'sd1, 24'sd0);
    send_item(24'sd6000000, -24'sd4000000);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    // Register defaults after reset.
    directed_set();
    // Field maxima but a zero noise threshold: dry share above one, a knee large enough to zero exp.
    write_all(65535, 65535, 131071, 65535, 131071, 131071, 0);
    directed_set();
    // Range minima but the largest pre-gain, low threshold, no knee, no wet gain.
    write_all(40960, 0, 0, 6554, 0, 1638, 655);
    directed_set();
    for (int ph = 0; ph < 8; ph++) begin
      write_all(pick_reg(0, 40960, 16), pick_reg(0, 40960, 16), pick_reg(0, 65536, 17),
                pick_reg(6554, 65535, 16), pick_reg(0, 65536, 17),
                pick_reg(1638, 65536, 17), pick_reg(655, 65536, 17));
      calm = (ph == 3);
      for (int i = 0; i < 240; i++) begin
        if (ph == 5 && i == 120) drain();
        send_item(pick_sample(), 24'($urandom));
      end
      calm = 1'b0;
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("soft_clip_noise_inject_mix verification clean");
    end else begin
      $display("soft_clip_noise_inject_mix verification failed");
    end
    $finish;
  end

endmodule
